/* sv/epof_pkg.sv */
// ----------------------------------------------------------------------------
// epof_pkg: shared types and constants of the pattern occurrence finder
// Holds the sizing constants, the request and response payload structs, and
// the control struct that the top level broadcasts to the cell row.
// ----------------------------------------------------------------------------
package epof_pkg;

	localparam int MAX_PATTERN   = 64;
	localparam int POSITION_BITS = 32;
	localparam int MIN_LEN       = 4;
	localparam int CFG_W         = 7;
	localparam int OUT_W         = 32;
	localparam int IDX_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W         = $clog2(MAX_PATTERN + 1);

	localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(MIN_LEN);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEXT = 1'b1
	} epof_op_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
		logic       end_of_text;
	} epof_req_t;

	typedef struct packed {
		logic             is_match;
		logic [OUT_W-1:0] start_position;
		logic [OUT_W-1:0] occurrence_count;
		logic             is_final;
	} epof_rsp_t;

	typedef struct packed {
		logic load;   // pattern byte request accepted
		logic step;   // text byte request accepted
		logic clear;  // drop all partial matches
	} epof_cell_ctl_t;

endpackage

/* sv/epof_cell.sv */
// ----------------------------------------------------------------------------
// epof_cell: one position of the pattern
// Stores one pattern byte and the match bit of that prefix length; takes the
// match bit of its left neighbor and hands its own bit to the right.
// ----------------------------------------------------------------------------
module epof_cell
	import epof_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  epof_cell_ctl_t ctl,
	input  logic           sel,
	input  logic           in_use,
	input  logic [7:0]     data_byte,
	input  logic           prev_bit,
	output logic           match_nxt,
	output logic           match_bit
);

	logic [7:0] pat_q;
	logic       match_q;

	// Prefix of this length matches if the shorter one did and this byte agrees.
	assign match_nxt = prev_bit & in_use & (pat_q == data_byte);
	assign match_bit = match_q;

	always_ff @(posedge clk) begin
		if (ctl.load && sel) begin
			pat_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.clear) begin
			match_q <= 1'b0;
		end else if (ctl.step) begin
			match_q <= match_nxt;
		end
	end

endmodule

/* sv/exact_pattern_occurrence_finder.sv */
// ----------------------------------------------------------------------------
// exact_pattern_occurrence_finder: exact byte pattern search over a stream
// A row of MAX_PATTERN cells keeps one pattern byte and one match bit each;
// the top level tracks load index, text position and occurrence count.
// ----------------------------------------------------------------------------
// Response timing: a response appears in the cycle after the text byte request that
//   causes it (output register); pattern loads give no response.
// Throughput: one request per cycle; the cell row shifts and compares all
//   pattern positions in the same cycle. The response register takes a new
//   result in the cycle its current one drains; a stalled response holds
//   off every request until it is taken.
// Reset: arst_n clears match bits, load index, position, count and the
//   length register (4); pattern bytes are undefined until loaded.

module exact_pattern_occurrence_finder
	import epof_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             req_valid,
	output logic             req_ready,
	input  epof_req_t        req_data,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output epof_rsp_t        rsp_data
);

	// Configuration and control state.
	logic [CFG_W-1:0]         len_cfg_q;
	logic [IDX_W-1:0]         load_idx_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [OUT_W-1:0]         cnt_q;
	logic                     rsp_valid_q;
	epof_rsp_t                rsp_q;

	logic [LEN_W-1:0]         len;
	logic [IDX_W-1:0]         hit_idx;
	logic                     req_fire;
	logic                     text_fire;
	logic                     load_fire;
	logic                     hit;
	logic                     emit;
	epof_cell_ctl_t           ctl;
	logic [MAX_PATTERN-1:0]   match_nxt;
	logic [MAX_PATTERN-1:0]   match_bits;
	logic [MAX_PATTERN-1:0]   prev_bits;

	logic [POSITION_BITS-1:0]       start_full;
	logic [OUT_W+POSITION_BITS-1:0] start_wide;
	logic [OUT_W-1:0]               cnt_nxt;
	logic [LEN_W-1:0]               load_idx_inc;

	// Clamp the programmed length to what the row supports.
	always_comb begin
		priority if (len_cfg_q < CFG_W'(MIN_LEN)) begin
			len = LEN_W'(MIN_LEN);
		end else if (LEN_W'(MAX_PATTERN) < len_cfg_q) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = LEN_W'(len_cfg_q);
		end
	end

	assign hit_idx = IDX_W'(len - LEN_W'(1));

	// Accept while the response register is empty or draining.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire  = req_valid && req_ready;
	assign text_fire = req_fire && (req_data.opcode == OP_TEXT);
	assign load_fire = req_fire && (req_data.opcode == OP_LOAD);

	// Drop partial matches on a load, a length write and after the last byte.
	assign ctl.load  = load_fire;
	assign ctl.step  = text_fire;
	assign ctl.clear = load_fire || cfg_we || (text_fire && req_data.end_of_text);

	// Cell row: cell 0 always sees a match of the empty prefix.
	assign prev_bits = {match_bits[MAX_PATTERN-2:0], 1'b1};

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		epof_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sel       (load_idx_q == IDX_W'(i)),
			.in_use    (LEN_W'(i) < len),
			.data_byte (req_data.data_byte),
			.prev_bit  (prev_bits[i]),
			.match_nxt (match_nxt[i]),
			.match_bit (match_bits[i])
		);
	end

	// An occurrence ends here when the full-length prefix matches.
	assign hit  = match_nxt[hit_idx];
	assign emit = text_fire && (hit || req_data.end_of_text);

	// Start offset, floored at zero, then fitted to the output width.
	always_comb begin
		if (pos_q >= POSITION_BITS'(hit_idx)) begin
			start_full = pos_q - POSITION_BITS'(hit_idx);
		end else begin
			start_full = '0;
		end
	end
	assign start_wide = {OUT_W'(0), start_full};

	assign cnt_nxt = (hit && (cnt_q != '1)) ? cnt_q + OUT_W'(1) : cnt_q;

	assign load_idx_inc = LEN_W'(load_idx_q) + LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q  <= LEN_RESET;
			load_idx_q <= '0;
		end else if (cfg_we) begin
			len_cfg_q  <= cfg_data;
			load_idx_q <= '0;
		end else if (load_fire) begin
			// Advance, wrapping after the last byte in use.
			load_idx_q <= (load_idx_inc >= len) ? '0 : IDX_W'(load_idx_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
		end else if (text_fire) begin
			if (req_data.end_of_text) begin
				pos_q <= '0;
				cnt_q <= '0;
			end else begin
				// Hold the position once it saturates.
				if (pos_q != '1) begin
					pos_q <= pos_q + POSITION_BITS'(1);
				end
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.is_match         <= hit;
			rsp_q.start_position   <= hit ? start_wide[OUT_W-1:0] : '0;
			rsp_q.occurrence_count <= cnt_nxt;
			rsp_q.is_final         <= req_data.end_of_text;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

/* sv/epof_checker.sv */
// ----------------------------------------------------------------------------
// epof_checker: port-level checks of the pattern occurrence finder
// Watches the request and response channels and flags illegal sequences.
// ----------------------------------------------------------------------------
module epof_checker
	import epof_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input epof_req_t        req_data,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input epof_rsp_t        rsp_data
);

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	// A waiting response blocks new requests.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request accepted while response stalled");

	// A response without a match only closes a text.
	a_nomatch_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.is_match |-> rsp_data.is_final &&
			(rsp_data.start_position == '0))
		else $error("non-match response not final or has start offset");

	// A match always counts at least itself.
	a_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.is_match |-> rsp_data.occurrence_count != '0)
		else $error("match with zero count");

	// A pattern load never yields a response in the next cycle.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.opcode == OP_LOAD) && !rsp_valid
		|=> !rsp_valid)
		else $error("response after pattern load");

endmodule

bind exact_pattern_occurrence_finder epof_checker u_epof_checker (.*);
